// ===== rtl/core/dcd_pkg.sv =====
package dcd_pkg;

  // pipeline depth, one register stage per entry
  localparam int NUM_STG = 7;

  // field widths
  localparam int DAY_W   = 32;
  localparam int MS_W    = 27;
  localparam int YEAR_W  = 24;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int WD_W    = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // internal widths
  localparam int ABS_W    = 31;  // magnitude of day count
  localparam int QY_W     = 23;  // whole years passed
  localparam int DOY_W    = 9;   // day of year 1..365
  localparam int RDOY_W   = 10;  // day remainder before correction
  localparam int OCT_W    = 7;   // sum of octal digits
  localparam int SECS_W   = 18;  // whole seconds
  localparam int MT_W     = 12;  // whole minutes
  localparam int HT_W     = 6;   // whole hours
  localparam int RMS_W    = 11;
  localparam int RMIN_W   = 7;
  localparam int RHOUR_W  = 13;

  // reciprocal multipliers: estimate is the quotient or one below
  localparam int DIV365_SH   = 40;
  localparam int DIV365_MW   = 32;
  localparam int DIV365_PW   = ABS_W + DIV365_MW;
  localparam logic [DIV365_MW-1:0] DIV365_MUL = DIV365_MW'((64'd1 << DIV365_SH) / 365);

  localparam int DIV1000_SH  = 37;
  localparam int DIV1000_MW  = 28;
  localparam int DIV1000_PW  = MS_W + DIV1000_MW;
  localparam logic [DIV1000_MW-1:0] DIV1000_MUL = DIV1000_MW'((64'd1 << DIV1000_SH) / 1000);

  localparam int DIV60_SH    = 24;
  localparam int DIV60_MW    = 19;
  localparam int DIV60_PW    = SECS_W + DIV60_MW;
  localparam logic [DIV60_MW-1:0] DIV60_MUL = DIV60_MW'((64'd1 << DIV60_SH) / 60);

  localparam int DIV3600_SH  = 29;
  localparam int DIV3600_MW  = 18;
  localparam int DIV3600_PW  = SECS_W + DIV3600_MW;
  localparam logic [DIV3600_MW-1:0] DIV3600_MUL =
    DIV3600_MW'((64'd1 << DIV3600_SH) / 3600);

  // calendar and clock constants
  localparam logic [ABS_W-1:0]   DAYS_PER_YEAR  = ABS_W'(365);
  localparam logic [DOY_W-1:0]   DOY_LAST       = DOY_W'(365);
  localparam logic [MS_W-1:0]    MS_PER_SEC     = MS_W'(1000);
  localparam logic [SECS_W-1:0]  SEC_PER_MIN    = SECS_W'(60);
  localparam logic [SECS_W-1:0]  SEC_PER_HOUR   = SECS_W'(3600);
  localparam logic [MT_W-1:0]    MIN_PER_HOUR   = MT_W'(60);
  localparam logic [HT_W-1:0]    HOURS_PER_DAY  = HT_W'(24);
  localparam logic [3:0]         DAYS_PER_WEEK  = 4'd7;
  localparam logic [3:0]         WEEK_SHIFT     = 4'd4;

  typedef logic [NUM_STG-1:0] stg_vec_t;

  // last day of year of month idx (0 is January)
  function automatic logic [DOY_W-1:0] month_end(input logic [3:0] idx);
    logic [DOY_W-1:0] e;
    case (idx)
      4'd0:    e = DOY_W'(31);
      4'd1:    e = DOY_W'(59);
      4'd2:    e = DOY_W'(90);
      4'd3:    e = DOY_W'(120);
      4'd4:    e = DOY_W'(151);
      4'd5:    e = DOY_W'(181);
      4'd6:    e = DOY_W'(212);
      4'd7:    e = DOY_W'(243);
      4'd8:    e = DOY_W'(273);
      4'd9:    e = DOY_W'(304);
      4'd10:   e = DOY_W'(334);
      default: e = DOY_W'(365);
    endcase
    return e;
  endfunction

  // days of the year before month m (1 is January)
  function automatic logic [DOY_W-1:0] month_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] b;
    case (m)
      4'd2:    b = DOY_W'(31);
      4'd3:    b = DOY_W'(59);
      4'd4:    b = DOY_W'(90);
      4'd5:    b = DOY_W'(120);
      4'd6:    b = DOY_W'(151);
      4'd7:    b = DOY_W'(181);
      4'd8:    b = DOY_W'(212);
      4'd9:    b = DOY_W'(243);
      4'd10:   b = DOY_W'(273);
      4'd11:   b = DOY_W'(304);
      4'd12:   b = DOY_W'(334);
      default: b = DOY_W'(0);
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/dcd_if.sv =====
interface dcd_in_if import dcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DAY_W-1:0]  day_number;
  logic        [MS_W-1:0]   millisecond_of_day;

  modport source (output valid, day_number, millisecond_of_day, input ready);
  modport sink   (input valid, day_number, millisecond_of_day, output ready);
endinterface

interface dcd_out_if import dcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [MONTH_W-1:0]       month;
  logic [DOM_W-1:0]         day_of_month;
  logic [WD_W-1:0]          weekday;
  logic [HOUR_W-1:0]        hour;
  logic [MIN_W-1:0]         minute;
  logic [SEC_W-1:0]         second;

  modport source (output valid, year, month, day_of_month, weekday, hour, minute, second,
                  input ready);
  modport sink   (input valid, year, month, day_of_month, weekday, hour, minute, second,
                  output ready);
endinterface

// ===== rtl/core/dcd_date_pipe.sv =====
module dcd_date_pipe import dcd_pkg::*; (
  input  logic                     clk,
  input  stg_vec_t                 en,
  input  logic signed [DAY_W-1:0]  day_number,
  output logic signed [YEAR_W-1:0] year,
  output logic [MONTH_W-1:0]       month,
  output logic [DOM_W-1:0]         day_of_month,
  output logic [WD_W-1:0]          weekday
);

  logic                   neg0_r;
  logic [ABS_W-1:0]       abs0_r;
  logic [DIV365_PW-1:0]   prod0_r;
  logic [OCT_W-1:0]       oct0_r;

  logic                   neg1_r;
  logic [QY_W-1:0]        q1_r;
  logic [RDOY_W-1:0]      r1_r;
  logic [3:0]             fold1_r;

  logic                   neg2_r;
  logic [QY_W-1:0]        q2_r;
  logic [DOY_W-1:0]       r2_r;
  logic [2:0]             xm2_r;

  logic signed [YEAR_W-1:0] year3_r;
  logic [DOY_W-1:0]       doy3_r;
  logic [WD_W-1:0]        wd3_r;

  logic signed [YEAR_W-1:0] year4_r;
  logic [DOY_W-1:0]       doy4_r;
  logic [MONTH_W-1:0]     month4_r;
  logic [WD_W-1:0]        wd4_r;

  logic signed [YEAR_W-1:0] year5_r;
  logic [MONTH_W-1:0]     month5_r;
  logic [DOM_W-1:0]       dom5_r;
  logic [WD_W-1:0]        wd5_r;

  logic signed [YEAR_W-1:0] year_r;
  logic [MONTH_W-1:0]     month_r;
  logic [DOM_W-1:0]       dom_r;
  logic [WD_W-1:0]        wd_r;

  logic [ABS_W-1:0]       abs_nxt;
  logic [OCT_W-1:0]       oct_nxt;
  logic [DAY_W-1:0]       biased;
  logic [ABS_W-1:0]       rem_full;
  logic [3:0]             s3;
  logic [QY_W-1:0]        yp;
  logic signed [YEAR_W-1:0] ypos;
  logic [3:0]             wsum;
  logic [MONTH_W-1:0]     month_nxt;
  logic [DOY_W-1:0]       dom_full;

  // stage 0: magnitude of the day number, reciprocal multiply, octal digit sum
  always_comb begin
    abs_nxt = day_number[DAY_W-1] ? ~day_number[ABS_W-1:0] : day_number[ABS_W-1:0];
    // day + 2^31 is nonnegative; 8 is 1 mod 7 so octal digits add up mod 7
    biased  = {~day_number[DAY_W-1], day_number[DAY_W-2:0]};
    oct_nxt = OCT_W'(biased[DAY_W-1:DAY_W-2]);
    for (int i = 0; i < 10; i++) begin
      oct_nxt = oct_nxt + OCT_W'(biased[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0_r  <= day_number[DAY_W-1];
      abs0_r  <= abs_nxt;
      prod0_r <= DIV365_PW'(abs_nxt) * DIV365_PW'(DIV365_MUL);
      oct0_r  <= oct_nxt;
    end
  end

  // stage 1: quotient estimate and its remainder
  assign rem_full = abs0_r - ABS_W'(ABS_W'(prod0_r[DIV365_PW-1:DIV365_SH]) * DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1_r  <= neg0_r;
      q1_r    <= prod0_r[DIV365_PW-1:DIV365_SH];
      r1_r    <= rem_full[RDOY_W-1:0];
      fold1_r <= 4'(oct0_r[6]) + 4'(oct0_r[5:3]) + 4'(oct0_r[2:0]);
    end
  end

  // stage 2: correct quotient, finish mod 7
  assign s3 = 4'(fold1_r[3]) + 4'(fold1_r[2:0]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2_r <= neg1_r;
      if (r1_r >= RDOY_W'(DAYS_PER_YEAR)) begin
        q2_r <= q1_r + QY_W'(1);
        r2_r <= DOY_W'(r1_r - RDOY_W'(DAYS_PER_YEAR));
      end else begin
        q2_r <= q1_r;
        r2_r <= r1_r[DOY_W-1:0];
      end
      xm2_r <= (s3 >= DAYS_PER_WEEK) ? 3'(s3 - DAYS_PER_WEEK) : s3[2:0];
    end
  end

  // stage 3: signed year, day of year, weekday
  always_comb begin
    yp   = q2_r + QY_W'(1);
    ypos = $signed({1'b0, yp});
    wsum = 4'(xm2_r) + WEEK_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      year3_r <= neg2_r ? -ypos : ypos;
      doy3_r  <= neg2_r ? (DOY_LAST - r2_r) : (r2_r + DOY_W'(1));
      wd3_r   <= (wsum >= DAYS_PER_WEEK) ? WD_W'(wsum - DAYS_PER_WEEK + 4'd1)
                                         : WD_W'(wsum + 4'd1);
    end
  end

  // stage 4: month by comparing against month ends
  always_comb begin
    month_nxt = MONTH_W'(1);
    for (int i = 0; i < 11; i++) begin
      month_nxt = month_nxt + MONTH_W'(doy3_r > month_end(4'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      year4_r  <= year3_r;
      doy4_r   <= doy3_r;
      month4_r <= month_nxt;
      wd4_r    <= wd3_r;
    end
  end

  // stage 5: day within the month
  assign dom_full = doy4_r - month_before(month4_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      year5_r  <= year4_r;
      month5_r <= month4_r;
      dom5_r   <= dom_full[DOM_W-1:0];
      wd5_r    <= wd4_r;
    end
  end

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (en[6]) begin
      year_r  <= year5_r;
      month_r <= month5_r;
      dom_r   <= dom5_r;
      wd_r    <= wd5_r;
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = dom_r;
  assign weekday      = wd_r;

endmodule

// ===== rtl/core/dcd_time_pipe.sv =====
module dcd_time_pipe import dcd_pkg::*; (
  input  logic              clk,
  input  stg_vec_t          en,
  input  logic [MS_W-1:0]   millisecond_of_day,
  output logic [HOUR_W-1:0] hour,
  output logic [MIN_W-1:0]  minute,
  output logic [SEC_W-1:0]  second
);

  logic [MS_W-1:0]        ms0_r;
  logic [DIV1000_PW-1:0]  pms0_r;

  logic [SECS_W-1:0]      q1_r;
  logic [RMS_W-1:0]       rem1_r;

  logic [SECS_W-1:0]      secs2_r;

  logic [SECS_W-1:0]      secs3_r;
  logic [DIV60_PW-1:0]    pmin3_r;
  logic [DIV3600_PW-1:0]  phour3_r;

  logic [MT_W-1:0]        mte4_r;
  logic [HT_W-1:0]        hte4_r;
  logic [RMIN_W-1:0]      rs4_r;
  logic [RHOUR_W-1:0]     rh4_r;

  logic [MT_W-1:0]        mt5_r;
  logic [HT_W-1:0]        ht5_r;
  logic [SEC_W-1:0]       sec5_r;

  logic [HOUR_W-1:0]      hour_r;
  logic [MIN_W-1:0]       min_r;
  logic [SEC_W-1:0]       sec_r;

  logic [MS_W-1:0]        ms_rem;
  logic [MT_W-1:0]        mte;
  logic [HT_W-1:0]        hte;
  logic [SECS_W-1:0]      rs_full;
  logic [SECS_W-1:0]      rh_full;
  logic [MT_W-1:0]        min_full;

  // stage 0: ms times reciprocal of 1000
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ms0_r  <= millisecond_of_day;
      pms0_r <= DIV1000_PW'(millisecond_of_day) * DIV1000_PW'(DIV1000_MUL);
    end
  end

  // stage 1: seconds estimate and leftover ms
  assign ms_rem = ms0_r - MS_W'(MS_W'(pms0_r[DIV1000_PW-1:DIV1000_SH]) * MS_PER_SEC);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1_r   <= pms0_r[DIV1000_PW-1:DIV1000_SH];
      rem1_r <= ms_rem[RMS_W-1:0];
    end
  end

  // stage 2: corrected whole seconds
  always_ff @(posedge clk) begin
    if (en[2]) begin
      secs2_r <= (rem1_r >= RMS_W'(MS_PER_SEC)) ? q1_r + SECS_W'(1) : q1_r;
    end
  end

  // stage 3: reciprocal multiplies for minutes and hours
  always_ff @(posedge clk) begin
    if (en[3]) begin
      secs3_r  <= secs2_r;
      pmin3_r  <= DIV60_PW'(secs2_r) * DIV60_PW'(DIV60_MUL);
      phour3_r <= DIV3600_PW'(secs2_r) * DIV3600_PW'(DIV3600_MUL);
    end
  end

  // stage 4: estimates and remainders
  always_comb begin
    mte     = pmin3_r[DIV60_SH +: MT_W];
    hte     = phour3_r[DIV3600_SH +: HT_W];
    rs_full = secs3_r - SECS_W'(SECS_W'(mte) * SEC_PER_MIN);
    rh_full = secs3_r - SECS_W'(SECS_W'(hte) * SEC_PER_HOUR);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mte4_r <= mte;
      hte4_r <= hte;
      rs4_r  <= rs_full[RMIN_W-1:0];
      rh4_r  <= rh_full[RHOUR_W-1:0];
    end
  end

  // stage 5: correct minutes, hours and second
  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (rs4_r >= RMIN_W'(SEC_PER_MIN)) begin
        mt5_r  <= mte4_r + MT_W'(1);
        sec5_r <= SEC_W'(rs4_r - RMIN_W'(SEC_PER_MIN));
      end else begin
        mt5_r  <= mte4_r;
        sec5_r <= rs4_r[SEC_W-1:0];
      end
      ht5_r <= (rh4_r >= RHOUR_W'(SEC_PER_HOUR)) ? hte4_r + HT_W'(1) : hte4_r;
    end
  end

  // stage 6: minute of hour, hour wraps at one day
  assign min_full = mt5_r - MT_W'(MT_W'(ht5_r) * MIN_PER_HOUR);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      min_r  <= min_full[MIN_W-1:0];
      hour_r <= (ht5_r >= HOURS_PER_DAY) ? HOUR_W'(ht5_r - HOURS_PER_DAY) : ht5_r[HOUR_W-1:0];
      sec_r  <= sec5_r;
    end
  end

  assign hour   = hour_r;
  assign minute = min_r;
  assign second = sec_r;

endmodule

// ===== rtl/core/day_count_to_calendar_date_core.sv =====
// an accepted request moves through stages 0 to 6 to its result on the output
// throughput: one request per cycle unless stalled; a stage advances if empty or if the
// stage after it moves, so bubbles close up and a stalled output holds only its own slot
// the 7 register stages hold the reciprocal multiplies by 365, 1000, 60 and 3600
// reset clears the stage valid bits; data registers are not reset
module day_count_to_calendar_date_core import dcd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  dcd_in_if.sink    in_ch,
  dcd_out_if.source out_ch
);

  stg_vec_t vld_r;
  stg_vec_t vld_nxt;
  stg_vec_t en;

  // stage advance, from the output back to the input
  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ch.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[NUM_STG-1];

  // calendar date and weekday
  dcd_date_pipe u_date (
    .clk          (clk),
    .en           (en),
    .day_number   (in_ch.day_number),
    .year         (out_ch.year),
    .month        (out_ch.month),
    .day_of_month (out_ch.day_of_month),
    .weekday      (out_ch.weekday)
  );

  // time of day
  dcd_time_pipe u_time (
    .clk                (clk),
    .en                 (en),
    .millisecond_of_day (in_ch.millisecond_of_day),
    .hour               (out_ch.hour),
    .minute             (out_ch.minute),
    .second             (out_ch.second)
  );

  // date fields in range on every result
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month >= 4'd1 && out_ch.month <= 4'd12 &&
                      out_ch.day_of_month >= 5'd1 && out_ch.day_of_month <= 5'd31 &&
                      out_ch.year != '0))
    else $error("date field out of range");

  // weekday in range
  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.weekday >= 3'd1 && out_ch.weekday <= 3'd7))
    else $error("weekday out of range");

  // time fields in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hour <= 5'd23 && out_ch.minute <= 6'd59 &&
                      out_ch.second <= 6'd59))
    else $error("time field out of range");

  // a request taken while the first stage holds an item means that item moved on
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && vld_r[0]) |=> vld_r[1])
    else $error("stage 0 item overwritten");

endmodule
